// ===== hw/rtl/tnps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-nearest point search package
// Default sizes shared by the search block and its users.
// ----------------------------------------------------------------------------
package tnps_pkg;

  // Default width of one signed coordinate.
  localparam int unsigned CoordBitsDefault = 20;
  // Default width of a point identifier.
  localparam int unsigned IdBitsDefault = 8;

endpackage

// ===== hw/rtl/two_nearest_point_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-nearest point search
// Scans a stream of candidate points and reports the nearest and the
// second-nearest point id to a query position at the end of each scan.
// ----------------------------------------------------------------------------
// The block takes one candidate point per clock cycle. The result item of a
// scan is presented once its last item has passed both stages. An item first
// lands in an input register; the two coordinate differences are squared by two
// parallel multipliers into a distance register; the final stage adds the
// squares, compares the sum against the kept nearest and second-nearest
// distances and updates them. Only the item marked with tlast produces a
// result item, which sits in an output register; ordinary items keep flowing
// while a result waits, and the pipeline stalls only when a second last item
// reaches the final stage before the previous result has been taken. A point
// whose id equals the excluded id is skipped but still counts towards the
// scan length. Scans of at most one item return the excluded id twice.
module two_nearest_point_search
  import tnps_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDefault,
  parameter int unsigned ID_BITS    = IdBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // Fields from bit 0 up: point_id, point_x, point_y, query_x, query_y,
  // excluded_id, zero padding.
  input  logic [((2*ID_BITS+4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  input  logic s_axis_tlast_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // Fields from bit 0 up: nearest_id, runner_up_id, zero padding.
  output logic [((2*ID_BITS+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int unsigned OutW  = ((2*ID_BITS+7)/8)*8;
  localparam int unsigned DiffW = COORD_BITS + 1;
  localparam int unsigned DistW = 2*COORD_BITS + 2;

  localparam int unsigned PxLo = ID_BITS;
  localparam int unsigned PyLo = PxLo + COORD_BITS;
  localparam int unsigned QxLo = PyLo + COORD_BITS;
  localparam int unsigned QyLo = QxLo + COORD_BITS;
  localparam int unsigned ExLo = QyLo + COORD_BITS;

  // --------------------------------------------------------------------------
  // Handshake chain
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s2_last_q;
  logic out_free, s2_fire, s2_ready, s1_ready, s1_move, in_fire;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s2_fire  = s2_valid_q && (!s2_last_q || out_free);
  assign s2_ready = !s2_valid_q || s2_fire;
  assign s1_move  = s1_valid_q && s2_ready;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign in_fire  = s_axis_tvalid_i && s1_ready;

  assign s_axis_tready_o = s1_ready;

  // --------------------------------------------------------------------------
  // Stage 1: input register
  // --------------------------------------------------------------------------
  logic        [ID_BITS-1:0]    s1_id_q, s1_excl_q;
  logic signed [COORD_BITS-1:0] s1_px_q, s1_py_q, s1_qx_q, s1_qy_q;
  logic                         s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_id_q   <= s_axis_tdata_i[ID_BITS-1:0];
      s1_px_q   <= s_axis_tdata_i[PxLo +: COORD_BITS];
      s1_py_q   <= s_axis_tdata_i[PyLo +: COORD_BITS];
      s1_qx_q   <= s_axis_tdata_i[QxLo +: COORD_BITS];
      s1_qy_q   <= s_axis_tdata_i[QyLo +: COORD_BITS];
      s1_excl_q <= s_axis_tdata_i[ExLo +: ID_BITS];
      s1_last_q <= s_axis_tlast_i;
    end
  end

  // Absolute differences fit in one bit more than a coordinate.
  logic signed [DiffW-1:0] diff_x, diff_y;
  logic        [DiffW-1:0] abs_x, abs_y;

  always_comb begin
    diff_x = {s1_px_q[COORD_BITS-1], s1_px_q} - {s1_qx_q[COORD_BITS-1], s1_qx_q};
    diff_y = {s1_py_q[COORD_BITS-1], s1_py_q} - {s1_qy_q[COORD_BITS-1], s1_qy_q};
    abs_x  = diff_x[DiffW-1] ? DiffW'(-diff_x) : DiffW'(diff_x);
    abs_y  = diff_y[DiffW-1] ? DiffW'(-diff_y) : DiffW'(diff_y);
  end

  // --------------------------------------------------------------------------
  // Stage 2: squared differences, then compare and update
  // --------------------------------------------------------------------------
  logic [DistW-1:0]   s2_sqx_q, s2_sqy_q;
  logic [ID_BITS-1:0] s2_id_q, s2_excl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_sqx_q  <= abs_x * abs_x;
      s2_sqy_q  <= abs_y * abs_y;
      s2_id_q   <= s1_id_q;
      s2_excl_q <= s1_excl_q;
      s2_last_q <= s1_last_q;
    end
  end

  // Kept scan state.
  logic [DistW-1:0]   best_dist_q, best_dist_d, sec_dist_q, sec_dist_d;
  logic [ID_BITS-1:0] best_idx_q, best_idx_d, sec_idx_q, sec_idx_d;
  logic               best_vld_q, best_vld_d, sec_vld_q, sec_vld_d;
  logic [1:0]         seen_q, seen_d;

  logic [DistW-1:0]   cand_dist;
  logic [ID_BITS-1:0] near_id, second_id;
  logic               short_scan;

  always_comb begin
    cand_dist   = s2_sqx_q + s2_sqy_q;
    best_dist_d = best_dist_q;
    best_idx_d  = best_idx_q;
    best_vld_d  = best_vld_q;
    sec_dist_d  = sec_dist_q;
    sec_idx_d   = sec_idx_q;
    sec_vld_d   = sec_vld_q;

    if (s2_id_q != s2_excl_q) begin
      // A tie never displaces the kept point that it ties with.
      if (!best_vld_q || cand_dist < best_dist_q) begin
        sec_dist_d  = best_dist_q;
        sec_idx_d   = best_idx_q;
        sec_vld_d   = best_vld_q;
        best_dist_d = cand_dist;
        best_idx_d  = s2_id_q;
        best_vld_d  = 1'b1;
      end else if (!sec_vld_q || cand_dist < sec_dist_q) begin
        sec_dist_d = cand_dist;
        sec_idx_d  = s2_id_q;
        sec_vld_d  = 1'b1;
      end
    end

    seen_d     = (seen_q == 2'd2) ? 2'd2 : seen_q + 2'd1;
    // After counting this item the scan holds at most one item.
    short_scan = (seen_q == 2'd0);

    if (short_scan) begin
      near_id   = s2_excl_q;
      second_id = s2_excl_q;
    end else begin
      near_id   = best_vld_d ? best_idx_d : s2_excl_q;
      second_id = sec_vld_d ? sec_idx_d : near_id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_dist_q <= '1;
      best_idx_q  <= '0;
      best_vld_q  <= 1'b0;
      sec_dist_q  <= '1;
      sec_idx_q   <= '0;
      sec_vld_q   <= 1'b0;
      seen_q      <= 2'd0;
    end else if (s2_fire) begin
      if (s2_last_q) begin
        best_dist_q <= '1;
        best_idx_q  <= '0;
        best_vld_q  <= 1'b0;
        sec_dist_q  <= '1;
        sec_idx_q   <= '0;
        sec_vld_q   <= 1'b0;
        seen_q      <= 2'd0;
      end else begin
        best_dist_q <= best_dist_d;
        best_idx_q  <= best_idx_d;
        best_vld_q  <= best_vld_d;
        sec_dist_q  <= sec_dist_d;
        sec_idx_q   <= sec_idx_d;
        sec_vld_q   <= sec_vld_d;
        seen_q      <= seen_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [ID_BITS-1:0] out_near_q, out_second_q;
  logic               out_load;

  assign out_load = s2_fire && s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_near_q   <= near_id;
      out_second_q <= second_id;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutW'({out_second_q, out_near_q});

endmodule
